// ----- rtl/layered_hit_shade_pack_defines.svh -----
// Assertion macros shared by the checker of the pixel shading block.
`ifndef LAYERED_HIT_SHADE_PACK_DEFINES_SVH
`define LAYERED_HIT_SHADE_PACK_DEFINES_SVH

// Property checked only while reset is released.
`define LHSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define LHSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lhsp_pkg.sv -----
// Constants, tables and stage types of the pixel shading pipeline.
package lhsp_pkg;

    localparam int LAYERS = 3;
    localparam int DOT_W  = 16;
    localparam int MAT_W  = 3;
    localparam int NODE_W = 16;
    localparam int CH     = 4;
    localparam int BYTE_W = 8;

    // Scaled channel sum: sum of weight * 255 * halves * |dot|.
    localparam int X_W   = 31;
    localparam int Y_W   = 15;
    localparam int LOW_W = 15;
    localparam int FN_W  = 8;
    localparam int NUM_W = 16;
    localparam int MUL_W = 33;

    // Layer weights in units of 1/125 (0.4, 0.24, 0.144), premultiplied by 255.
    localparam logic [13:0] LAYER_WT255 [3] = '{14'd12750, 14'd7650, 14'd4590};

    // The channel limits at 255 once the sum reaches the full scale.
    localparam logic [X_W-1:0] SAT_X = 31'd1044480000;

    // Reciprocals for division by 125 and 199, both scaled by two to the 24th.
    localparam logic [17:0] RECIP_125 = 18'd134218;
    localparam logic [16:0] RECIP_199 = 17'd84308;
    localparam int          RECIP_SH  = 24;

    localparam logic [Y_W-1:0]   DIV_125  = 15'd125;
    localparam logic [Y_W-1:0]   R_HALF   = 15'd62;
    localparam logic [LOW_W-1:0] LOW_HALF = 15'd16384;
    localparam logic [NUM_W-1:0] DIV_199  = 16'd199;
    localparam logic [NUM_W-1:0] R_UP_199 = 16'd100;

    localparam logic [NODE_W-1:0] NODE_MAX = 16'd200;
    localparam logic [FN_W-1:0]   T_MAX    = 8'd199;
    localparam logic [9:0] SEG_BASE [4] = '{10'd0, 10'd199, 10'd398, 10'd597};

    // Palette channels in halves, index 0 = red ... 3 = alpha.
    typedef logic [CH-1:0][1:0] t_halves;

    localparam t_halves PAL_HALVES [8] = '{
        '{2'd2, 2'd2, 2'd2, 2'd2},
        '{2'd2, 2'd0, 2'd2, 2'd0},
        '{2'd2, 2'd2, 2'd0, 2'd0},
        '{2'd2, 2'd0, 2'd2, 2'd2},
        '{2'd2, 2'd2, 2'd0, 2'd2},
        '{2'd2, 2'd2, 2'd2, 2'd0},
        '{2'd2, 2'd1, 2'd1, 2'd2},
        '{2'd2, 2'd2, 2'd1, 2'd1}
    };
    localparam t_halves DEBUG_ENTRY0 = '{2'd2, 2'd1, 2'd1, 2'd2};

    // Gradient stops, bit 0 = red, bit 1 = green, bit 2 = blue.
    localparam logic [2:0] GRAD_STOP [5] = '{3'b100, 3'b110, 3'b010, 3'b011, 3'b001};

    typedef enum logic [0:0] {
        CFG_HEATMAP = 1'b0,
        CFG_PALETTE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                            hit;
        logic                            heat;
        logic [LAYERS-1:0][DOT_W-1:0]    dmag;
        logic [LAYERS-1:0][CH-1:0][1:0]  halves;
        logic [1:0]                      gidx;
        logic [FN_W-1:0]                 gfn;
    } t_s1;

    typedef struct packed {
        logic                      hit;
        logic                      heat;
        logic [CH-1:0][X_W-1:0]    x;
        logic [1:0]                gidx;
        logic [NUM_W-1:0]          hnum;
    } t_s2;

    typedef struct packed {
        logic                        hit;
        logic                        heat;
        logic [CH-1:0]               sat;
        logic [CH-1:0][BYTE_W-1:0]   q;
        logic [CH-1:0][Y_W-1:0]      y;
        logic [CH-1:0][LOW_W-1:0]    low;
        logic [1:0]                  gidx;
        logic [BYTE_W-1:0]           hq;
        logic [NUM_W-1:0]            hnum;
    } t_s3;

endpackage

// ----- rtl/lhsp_decode.sv -----
// First stage: dot magnitudes, palette lookup and gradient segment.
module lhsp_decode
    import lhsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic                i_heatmap,
    input  logic                i_palette,
    input  logic                i_hit_flag,
    input  logic [MAT_W-1:0]    i_layer0_material,
    input  logic [MAT_W-1:0]    i_layer1_material,
    input  logic [MAT_W-1:0]    i_layer2_material,
    input  logic signed [DOT_W-1:0] i_layer0_dot,
    input  logic signed [DOT_W-1:0] i_layer1_dot,
    input  logic signed [DOT_W-1:0] i_layer2_dot,
    input  logic [NODE_W-1:0]   i_nodes_visited,
    output logic                o_valid,
    output t_s1                 o_s1
);

    logic                r_valid;
    t_s1                 r_s1;
    t_s1                 n_s1;
    logic [MAT_W-1:0]    w_mat [3];
    logic [DOT_W-1:0]    w_dot [3];
    logic [FN_W-1:0]     w_t;
    logic [9:0]          w_t4;
    logic [1:0]          w_idx;
    logic [9:0]          w_fn;

    assign w_mat[0] = i_layer0_material;
    assign w_mat[1] = i_layer1_material;
    assign w_mat[2] = i_layer2_material;
    assign w_dot[0] = i_layer0_dot;
    assign w_dot[1] = i_layer1_dot;
    assign w_dot[2] = i_layer2_dot;

    // Node count clamped to 1..200, then offset to 0..199.
    always_comb begin
        priority if (i_nodes_visited == '0) begin
            w_t = '0;
        end else if (i_nodes_visited > NODE_MAX) begin
            w_t = T_MAX;
        end else begin
            w_t = i_nodes_visited[FN_W-1:0] - 8'd1;
        end
    end

    assign w_t4 = {w_t, 2'b00};

    // Segment index; the top end folds into the last segment.
    always_comb begin
        priority if (w_t4 >= SEG_BASE[3]) begin
            w_idx = 2'd3;
        end else if (w_t4 >= SEG_BASE[2]) begin
            w_idx = 2'd2;
        end else if (w_t4 >= SEG_BASE[1]) begin
            w_idx = 2'd1;
        end else begin
            w_idx = 2'd0;
        end
    end

    assign w_fn = w_t4 - SEG_BASE[w_idx];

    always_comb begin
        n_s1      = '0;
        n_s1.hit  = i_hit_flag;
        n_s1.heat = i_heatmap;
        n_s1.gidx = w_idx;
        n_s1.gfn  = w_fn[FN_W-1:0];
        for (int n = 0; n < LAYERS; n++) begin
            // Negating the most negative code gives 32768, which still fits unsigned.
            n_s1.dmag[n] = w_dot[n][DOT_W-1] ? (~w_dot[n] + 16'd1) : w_dot[n];
            if ((w_mat[n] == '0) && i_palette) begin
                n_s1.halves[n] = DEBUG_ENTRY0;
            end else begin
                n_s1.halves[n] = PAL_HALVES[w_mat[n]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

// ----- rtl/lhsp_accum.sv -----
// Second and third stages: weighted channel sums, then reciprocal multiplies.
module lhsp_accum
    import lhsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_s1     i_s1,
    output logic    o_valid,
    output t_s3     o_s3
);

    logic                r_valid2;
    logic                r_valid3;
    t_s2                 r_s2;
    t_s2                 n_s2;
    t_s3                 r_s3;
    t_s3                 n_s3;
    logic [DOT_W:0]      w_term;
    logic [MUL_W-1:0]    w_prod [CH];
    logic [MUL_W-1:0]    w_prodh;

    always_comb begin
        n_s2      = '0;
        w_term    = '0;
        n_s2.hit  = i_s1.hit;
        n_s2.heat = i_s1.heat;
        n_s2.gidx = i_s1.gidx;
        n_s2.hnum = {i_s1.gfn, 8'd0} - {8'd0, i_s1.gfn};
        for (int c = 0; c < CH; c++) begin
            for (int n = 0; n < LAYERS; n++) begin
                unique case (i_s1.halves[n][c])
                    2'd1:    w_term = {1'b0, i_s1.dmag[n]};
                    2'd2:    w_term = {i_s1.dmag[n], 1'b0};
                    default: w_term = '0;
                endcase
                n_s2.x[c] = n_s2.x[c] + X_W'(LAYER_WT255[n]) * X_W'(w_term);
            end
        end
    end

    always_comb begin
        n_s3      = '0;
        n_s3.hit  = r_s2.hit;
        n_s3.heat = r_s2.heat;
        n_s3.gidx = r_s2.gidx;
        n_s3.hnum = r_s2.hnum;
        for (int c = 0; c < CH; c++) begin
            n_s3.sat[c] = (r_s2.x[c] >= SAT_X);
            // Below the limit x fits in 30 bits, so the quotient input needs 15.
            n_s3.y[c]   = r_s2.x[c][29:15];
            n_s3.low[c] = r_s2.x[c][LOW_W-1:0];
            w_prod[c]   = MUL_W'(r_s2.x[c][29:15]) * MUL_W'(RECIP_125);
            n_s3.q[c]   = w_prod[c][RECIP_SH+BYTE_W-1:RECIP_SH];
        end
        w_prodh = MUL_W'(r_s2.hnum) * MUL_W'(RECIP_199);
        n_s3.hq = w_prodh[RECIP_SH+BYTE_W-1:RECIP_SH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else if (i_en) begin
            r_valid2 <= i_valid;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_valid3;
    assign o_s3    = r_s3;

endmodule

// ----- rtl/lhsp_resolve.sv -----
// Last stage: remainder, rounding to nearest even, mode select and output register.
module lhsp_resolve
    import lhsp_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  t_s3                          i_s3,
    output logic                         o_valid,
    output logic [CH-1:0][BYTE_W-1:0]    o_rgba
);

    logic                          r_valid;
    logic [CH-1:0][BYTE_W-1:0]     r_rgba;
    logic [CH-1:0][BYTE_W-1:0]     n_rgba;
    logic [CH-1:0][BYTE_W-1:0]     w_shade;
    logic [2:0][BYTE_W-1:0]        w_grad;
    logic [Y_W-1:0]                w_r [CH];
    logic                          w_up [CH];
    logic [NUM_W-1:0]              w_rh;
    logic [BYTE_W-1:0]             w_a;
    logic [2:0]                    w_sa;
    logic [2:0]                    w_sb;

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            w_r[c]  = i_s3.y[c] - Y_W'(i_s3.q[c]) * DIV_125;
            // Exact halfway only when the remainder sits at 62 and the low part at 16384.
            w_up[c] = (w_r[c] > R_HALF) ||
                      ((w_r[c] == R_HALF) && ((i_s3.low[c] > LOW_HALF) ||
                       ((i_s3.low[c] == LOW_HALF) && i_s3.q[c][0])));
            w_shade[c] = i_s3.sat[c] ? 8'hFF : (i_s3.q[c] + BYTE_W'(w_up[c]));
        end
    end

    // The odd span never gives a tie, so the falling channel is 255 minus the rising one.
    always_comb begin
        w_rh = i_s3.hnum - NUM_W'(i_s3.hq) * DIV_199;
        w_a  = i_s3.hq + BYTE_W'(w_rh >= R_UP_199);
        w_sa = GRAD_STOP[3'(i_s3.gidx)];
        w_sb = GRAD_STOP[3'(i_s3.gidx) + 3'd1];
        for (int c = 0; c < 3; c++) begin
            priority if (w_sa[c] && w_sb[c]) begin
                w_grad[c] = 8'hFF;
            end else if (w_sa[c]) begin
                w_grad[c] = 8'hFF - w_a;
            end else if (w_sb[c]) begin
                w_grad[c] = w_a;
            end else begin
                w_grad[c] = '0;
            end
        end
    end

    always_comb begin
        priority if (!i_s3.hit) begin
            n_rgba = '0;
        end else if (i_s3.heat) begin
            n_rgba = {8'hFF, w_grad[2], w_grad[1], w_grad[0]};
        end else begin
            n_rgba = w_shade;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgba <= n_rgba;
        end
    end

    assign o_valid = r_valid;
    assign o_rgba  = r_rgba;

endmodule

// ----- rtl/layered_hit_shade_pack.sv -----
// Pixel shader top level: shades one traced pixel into an RGBA byte quad.
// Input channel: i_valid / o_stall with the hit flag, three layer materials,
// three Q1.14 dots and the visited node count; an item is taken at an edge
// where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with red, green, blue and alpha; the
// receiver takes an item at an edge where o_valid is high and i_stall is low.
// Configuration: i_cfg_valid / o_cfg_ready, index 0 = heatmap mode, index 1 =
// palette select; o_cfg_ready is always high. Write only while the pipe is empty.
// An accepted item passes four register stages: decode, weighted sum, reciprocal
// multiply and rounding, each advancing together. o_valid rises when the item
// reaches the rounding register, and the item leaves from there. One item enters
// every cycle while the receiver does not stall.
// When the receiver stalls a waiting item, all stages hold and o_stall rises in
// the same cycle; nothing is dropped or repeated.
// Synchronous reset clears all stage valid bits and both configuration registers.
module layered_hit_shade_pack
    import lhsp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_hit_flag,
    input  logic [MAT_W-1:0]        i_layer0_material,
    input  logic [MAT_W-1:0]        i_layer1_material,
    input  logic [MAT_W-1:0]        i_layer2_material,
    input  logic signed [DOT_W-1:0] i_layer0_dot,
    input  logic signed [DOT_W-1:0] i_layer1_dot,
    input  logic signed [DOT_W-1:0] i_layer2_dot,
    input  logic [NODE_W-1:0]       i_nodes_visited,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [BYTE_W-1:0]       o_red,
    output logic [BYTE_W-1:0]       o_green,
    output logic [BYTE_W-1:0]       o_blue,
    output logic [BYTE_W-1:0]       o_alpha,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [0:0]              i_cfg_index,
    input  logic                    i_cfg_data
);

    logic                        r_heatmap;
    logic                        r_palette;
    logic                        w_en;
    logic                        w_v1;
    logic                        w_v3;
    logic                        w_v4;
    t_s1                         w_s1;
    t_s3                         w_s3;
    logic [CH-1:0][BYTE_W-1:0]   w_rgba;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heatmap <= 1'b0;
            r_palette <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_HEATMAP: r_heatmap <= i_cfg_data;
                CFG_PALETTE: r_palette <= i_cfg_data;
            endcase
        end
    end

    // The whole pipe advances unless a finished item is held by the receiver.
    assign w_en    = !(w_v4 && i_stall);
    assign o_stall = !w_en;

    lhsp_decode u_decode (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_valid           (i_valid),
        .i_heatmap         (r_heatmap),
        .i_palette         (r_palette),
        .i_hit_flag        (i_hit_flag),
        .i_layer0_material (i_layer0_material),
        .i_layer1_material (i_layer1_material),
        .i_layer2_material (i_layer2_material),
        .i_layer0_dot      (i_layer0_dot),
        .i_layer1_dot      (i_layer1_dot),
        .i_layer2_dot      (i_layer2_dot),
        .i_nodes_visited   (i_nodes_visited),
        .o_valid           (w_v1),
        .o_s1              (w_s1)
    );

    lhsp_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v1),
        .i_s1    (w_s1),
        .o_valid (w_v3),
        .o_s3    (w_s3)
    );

    lhsp_resolve u_resolve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_v3),
        .i_s3    (w_s3),
        .o_valid (w_v4),
        .o_rgba  (w_rgba)
    );

    assign o_valid = w_v4;
    assign o_red   = w_rgba[0];
    assign o_green = w_rgba[1];
    assign o_blue  = w_rgba[2];
    assign o_alpha = w_rgba[3];

endmodule

// ----- rtl/lhsp_checker.sv -----
// Port-level checks of the pixel shader, bound to its top level.
`include "layered_hit_shade_pack_defines.svh"

module lhsp_checker
    import lhsp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    o_stall,
    input  logic                    i_hit_flag,
    input  logic                    o_valid,
    input  logic                    i_stall,
    input  logic [BYTE_W-1:0]       o_red,
    input  logic [BYTE_W-1:0]       o_green,
    input  logic [BYTE_W-1:0]       o_blue,
    input  logic [BYTE_W-1:0]       o_alpha
);

    // A missed pixel that flows through unstalled comes out black.
    `LHSP_ASSERT(a_miss_black, i_clk, i_rst_n, (i_valid && !o_stall && !i_hit_flag) ##1 !o_stall ##1 !o_stall ##1 !o_stall |=> (o_valid && o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0 && o_alpha == 8'd0), "missed pixel did not come out black")

    // The input side only stalls when the output item is held.
    `LHSP_ASSERT(a_no_false_stall, i_clk, i_rst_n, !(o_valid && i_stall) |-> !o_stall, "input stalled while output drains")

    // A held output item stays put.
    `LHSP_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_alpha)), "stalled output item changed")

    // Reset empties the pipe.
    `LHSP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind layered_hit_shade_pack lhsp_checker u_lhsp_checker (.*);

// ----- tb/layered_hit_shade_pack_tb.sv -----
// Self-checking testbench for the layered hit shading and heatmap pixel block.
module layered_hit_shade_pack_tb
    import lhsp_pkg::*;
();

    typedef struct packed {
        logic                    hit;
        logic [2:0][MAT_W-1:0]   mat;
        logic [2:0][DOT_W-1:0]   dot;
        logic [NODE_W-1:0]       nodes;
    } t_pixel;

    typedef struct packed {
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] g;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] a;
    } t_rgba;

    // Layer weights in thousandths, palette channels in halves (R G B A).
    localparam int unsigned SHADE_WT [3] = '{400, 240, 144};
    localparam longint unsigned SHADE_DEN = 64'd32768000;
    localparam int unsigned PAL_TAB [8][4] = '{
        '{2, 2, 2, 2}, '{0, 2, 0, 2}, '{0, 0, 2, 2}, '{2, 2, 0, 2},
        '{2, 0, 2, 2}, '{0, 2, 2, 2}, '{2, 1, 1, 2}, '{1, 1, 2, 2}
    };
    localparam int unsigned DBG_ZERO [4] = '{2, 1, 1, 2};
    // Heatmap ramp: blue, cyan, green, yellow, red (R G B).
    localparam int unsigned RAMP_STOP [5][3] = '{
        '{0, 0, 1}, '{0, 1, 1}, '{0, 1, 0}, '{1, 1, 0}, '{1, 0, 0}
    };
    localparam int unsigned NODES_LO  = 1;
    localparam int unsigned NODES_HI  = 200;
    localparam int unsigned RAMP_SPAN = NODES_HI - NODES_LO;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 80;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_hit_flag = 1'b0;
    logic [MAT_W-1:0]        i_layer0_material = '0;
    logic [MAT_W-1:0]        i_layer1_material = '0;
    logic [MAT_W-1:0]        i_layer2_material = '0;
    logic signed [DOT_W-1:0] i_layer0_dot = '0;
    logic signed [DOT_W-1:0] i_layer1_dot = '0;
    logic signed [DOT_W-1:0] i_layer2_dot = '0;
    logic [NODE_W-1:0]       i_nodes_visited = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [BYTE_W-1:0]       o_red;
    logic [BYTE_W-1:0]       o_green;
    logic [BYTE_W-1:0]       o_blue;
    logic [BYTE_W-1:0]       o_alpha;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [0:0]              i_cfg_index = '0;
    logic                    i_cfg_data = 1'b0;

    layered_hit_shade_pack u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_hit_flag        (i_hit_flag),
        .i_layer0_material (i_layer0_material),
        .i_layer1_material (i_layer1_material),
        .i_layer2_material (i_layer2_material),
        .i_layer0_dot      (i_layer0_dot),
        .i_layer1_dot      (i_layer1_dot),
        .i_layer2_dot      (i_layer2_dot),
        .i_nodes_visited   (i_nodes_visited),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_red             (o_red),
        .o_green           (o_green),
        .o_blue            (o_blue),
        .o_alpha           (o_alpha),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic heat_mode = 1'b0;
    logic pal_debug = 1'b0;

    t_pixel pixel_q [$];
    t_rgba  rgba_q [$];
    t_pixel cur_px;
    int     n_queued = 0;
    int     n_taken = 0;
    int     n_shaded = 0;
    int     n_errs = 0;
    int     tx_gap = 0;
    int     tx_calm = 0;
    int     rx_calm = 0;
    int     rx_stall_left = 0;
    int     rx_run_left = 0;
    int     hold_cnt = 0;
    bit     hold_done = 1'b0;
    int     idle_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, and now and then a calm run with none.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Limit at 255, then round to nearest with ties to even.
    function automatic logic [7:0] round_sat(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        if (num >= 255 * den) return 8'd255;
        q = num / den;
        r = num % den;
        if (2 * r > den || (2 * r == den && q[0])) q++;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic t_rgba shade_pixel(t_pixel p);
        t_rgba           px;
        longint unsigned acc [4];
        logic [7:0]      ch [4];
        int unsigned     v, t, seg, fn, mag, halves, num;
        px = '0;
        if (!p.hit) return px;
        if (heat_mode) begin
            v = 32'(p.nodes);
            if (v < NODES_LO) v = NODES_LO;
            if (v > NODES_HI) v = NODES_HI;
            t = v - NODES_LO;
            seg = (4 * t) / RAMP_SPAN;
            if (seg > 3) seg = 3;
            fn = 4 * t - RAMP_SPAN * seg;
            for (int c = 0; c < 3; c++) begin
                num = (RAMP_STOP[seg][c] * (RAMP_SPAN - fn) + RAMP_STOP[seg + 1][c] * fn) * 255;
                ch[c] = round_sat(64'(num), 64'(RAMP_SPAN));
            end
            ch[3] = 8'd255;
        end else begin
            for (int c = 0; c < 4; c++) acc[c] = 0;
            for (int n = 0; n < 3; n++) begin
                // The most negative code has magnitude 32768.
                mag = p.dot[n][DOT_W-1] ? 32'h10000 - 32'(p.dot[n]) : 32'(p.dot[n]);
                for (int c = 0; c < 4; c++) begin
                    halves = (p.mat[n] == 0 && pal_debug) ? DBG_ZERO[c] : PAL_TAB[p.mat[n]][c];
                    acc[c] += longint'(SHADE_WT[n]) * halves * mag;
                end
            end
            for (int c = 0; c < 4; c++) ch[c] = round_sat(acc[c] * 255, SHADE_DEN);
        end
        px.r = ch[0];
        px.g = ch[1];
        px.b = ch[2];
        px.a = ch[3];
        return px;
    endfunction

    function automatic t_pixel mk_pixel(logic hit, logic [MAT_W-1:0] m0, logic [MAT_W-1:0] m1,
                                        logic [MAT_W-1:0] m2, logic [DOT_W-1:0] d0,
                                        logic [DOT_W-1:0] d1, logic [DOT_W-1:0] d2,
                                        logic [NODE_W-1:0] nodes);
        t_pixel p;
        p.hit = hit;
        p.mat = {m2, m1, m0};
        p.dot = {d2, d1, d0};
        p.nodes = nodes;
        return p;
    endfunction

    task automatic queue_pixel(t_pixel p);
        pixel_q.push_back(p);
        n_queued++;
    endtask

    task automatic queue_random(int count);
        t_pixel p;
        int     r;
        for (int k = 0; k < count; k++) begin
            p.hit = ($urandom_range(0, 9) != 0);
            p.mat = 9'($urandom);
            for (int n = 0; n < 3; n++) begin
                r = $urandom_range(0, 9);
                if (r < 6) p.dot[n] = 16'($urandom_range(0, 32768) - 16384);
                else if (r == 6) p.dot[n] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                else if (r == 7) p.dot[n] = '0;
                else p.dot[n] = 16'($urandom);
            end
            p.nodes = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 220)) : 16'($urandom);
            queue_pixel(p);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HEATMAP) heat_mode = val;
        else pal_debug = val;
    endtask

    task automatic set_mode(logic heat, logic pal);
        write_reg(CFG_HEATMAP, heat);
        write_reg(CFG_PALETTE, pal);
    endtask

    // Wait until every item is through and the pipe has had time to empty.
    task automatic drain();
        while (n_taken != n_queued || rgba_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic check_byte(string chan, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            n_errs++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, chan, want, got);
        end
    endtask

    // Input driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                rgba_q.push_back(shade_pixel(cur_px));
                n_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    cur_px = pixel_q.pop_front();
                    i_hit_flag        <= cur_px.hit;
                    i_layer0_material <= cur_px.mat[0];
                    i_layer1_material <= cur_px.mat[1];
                    i_layer2_material <= cur_px.mat[2];
                    i_layer0_dot      <= cur_px.dot[0];
                    i_layer1_dot      <= cur_px.dot[1];
                    i_layer2_dot      <= cur_px.dot[2];
                    i_nodes_visited   <= cur_px.nodes;
                    i_valid <= 1'b1;
                    tx_gap = pick_gap(tx_calm);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and receiver stall.
    always @(posedge i_clk) begin
        t_rgba want;
        logic  stall_nxt;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (rgba_q.size() == 0) begin
                    n_errs++;
                    $display("%0t: unexpected item, expected none, got %0d %0d %0d %0d",
                             $time, o_red, o_green, o_blue, o_alpha);
                end else begin
                    want = rgba_q.pop_front();
                    check_byte("red", want.r, o_red);
                    check_byte("green", want.g, o_green);
                    check_byte("blue", want.b, o_blue);
                    check_byte("alpha", want.a, o_alpha);
                end
                n_shaded++;
            end
            // One long hold-off lets the pipe fill and push back on the sender.
            if (!hold_done && n_shaded >= 150) begin
                hold_cnt = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                stall_nxt = 1'b1;
            end else if (rx_stall_left > 0) begin
                rx_stall_left--;
                stall_nxt = 1'b1;
            end else if (rx_run_left > 0) begin
                rx_run_left--;
                stall_nxt = 1'b0;
            end else begin
                rx_stall_left = pick_gap(rx_calm);
                rx_run_left = $urandom_range(0, 6);
                stall_nxt = (rx_stall_left > 0);
                if (stall_nxt) rx_stall_left--;
            end
            i_stall <= stall_nxt;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Layered shading, standard palette.
        set_mode(1'b0, 1'b0);
        queue_pixel(mk_pixel(1'b0, 3'd7, 3'd7, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        for (int m = 0; m < 8; m++)
            queue_pixel(mk_pixel(1'b1, 3'(m), 3'((m + 1) % 8), 3'((m + 2) % 8),
                                 16'sd16384, -16'sd16384, 16'sd8192, 16'(m * 7)));
        queue_pixel(mk_pixel(1'b1, 3'd0, 3'd0, 3'd0, 16'h8000, 16'h8000, 16'h8000, 16'd0));
        queue_pixel(mk_pixel(1'b1, 3'd3, 3'd3, 3'd3, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd5));
        queue_pixel(mk_pixel(1'b1, 3'd6, 3'd1, 3'd4, 16'd0, 16'd0, 16'd0, 16'd9));
        queue_pixel(mk_pixel(1'b1, 3'd7, 3'd2, 3'd5, 16'd1, 16'hFFFF, 16'd1, 16'd300));
        queue_random(95);
        drain();

        // Debug palette changes entry zero.
        set_mode(1'b0, 1'b1);
        queue_pixel(mk_pixel(1'b1, 3'd0, 3'd0, 3'd0, 16'sd16384, 16'sd16384, 16'sd16384, 16'd1));
        queue_pixel(mk_pixel(1'b1, 3'd5, 3'd0, 3'd2, 16'sd4000, -16'sd12000, 16'sd300, 16'd2));
        queue_random(95);
        drain();

        // Heatmap: clamps at both ends, segment edges and the top of the ramp.
        set_mode(1'b1, 1'b0);
        queue_pixel(mk_pixel(1'b1, 3'd0, 3'd0, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        queue_pixel(mk_pixel(1'b1, 3'd1, 3'd2, 3'd3, 16'd0, 16'd0, 16'd0, 16'd1));
        queue_pixel(mk_pixel(1'b1, 3'd1, 3'd2, 3'd3, 16'd0, 16'd0, 16'd0, 16'd2));
        queue_pixel(mk_pixel(1'b1, 3'd4, 3'd5, 3'd6, 16'd0, 16'd0, 16'd0, 16'd51));
        queue_pixel(mk_pixel(1'b1, 3'd4, 3'd5, 3'd6, 16'd0, 16'd0, 16'd0, 16'd100));
        queue_pixel(mk_pixel(1'b1, 3'd7, 3'd0, 3'd1, 16'd0, 16'd0, 16'd0, 16'd199));
        queue_pixel(mk_pixel(1'b1, 3'd7, 3'd0, 3'd1, 16'd0, 16'd0, 16'd0, 16'd200));
        queue_pixel(mk_pixel(1'b1, 3'd2, 3'd3, 3'd4, 16'd0, 16'd0, 16'd0, 16'd201));
        queue_pixel(mk_pixel(1'b1, 3'd2, 3'd3, 3'd4, 16'd0, 16'd0, 16'd0, 16'hFFFF));
        queue_pixel(mk_pixel(1'b0, 3'd2, 3'd3, 3'd4, 16'd0, 16'd0, 16'd0, 16'd100));
        queue_random(95);
        drain();

        set_mode(1'b1, 1'b1);
        queue_random(95);
        drain();

        set_mode(1'b0, 1'b1);
        queue_random(95);
        drain();

        set_mode(1'b0, 1'b0);
        queue_random(95);
        drain();

        if (n_errs == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
